>>> rtl/core/wsd_pkg.sv
package wsd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 64;
  localparam int unsigned KEY_BYTES   = 4;
  localparam int unsigned OUT_FIELD_W = 1 + 1 + 1 + 1 + 4 + 1 + LEN_W + BYTE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // 7-bit length codes that select an extended length field
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;
  localparam logic [3:0] KEY_LEN_BYTES = 4'd4;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              fin;
    logic              rsv1;
    logic              rsv2;
    logic              rsv3;
    logic [3:0]        opcode;
    logic              masked;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] data_out;
    logic              last;
  } result_t;

endpackage

>>> rtl/core/websocket_frame_deframer.sv
// Channel   Dir  Payload
// s_axis    in   tdata: data_byte[7:0]; tuser: flush
// m_axis    out  tdata: fin, rsv1, rsv2, rsv3, opcode, masked, payload_length,
//                data_out, zero fill; tuser: kind; tlast: last
//
// One byte per cycle while s_axis_tready is high; a result from an input byte is registered.
// The frame state updates in a single pass of logic per byte; a one-entry skid
// stage behind the result register keeps tready registered; a stall on m_axis
// backs up to s_axis when the skid fills. Only the byte that completes a
// header yields the header result; other header and key bytes give none.
// rst is synchronous, active high, and returns the parser to the frame start.
module websocket_frame_deframer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wsd_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] data_byte
  input  logic                                s_axis_tuser,  // [0] flush
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] fin, [1] rsv1, [2] rsv2, [3] rsv3, [7:4] opcode, [8] masked,
  // [72:9] payload_length, [80:73] data_out, [87:81] zero
  output logic [wsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,  // [0] kind
  output logic                                m_axis_tlast
);

  typedef enum logic [2:0] {
    PH_B0,
    PH_B1,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t                           phase, phase_next;
  logic [3:0]                       field_byte_count, field_byte_count_next;
  logic [wsd_pkg::BYTE_W-1:0]       first_byte, first_byte_next;
  logic                             mask_flag, mask_flag_next;
  logic [wsd_pkg::LEN_W-1:0]        length_accumulator, length_accumulator_next;
  logic [wsd_pkg::KEY_BYTES-1:0][wsd_pkg::BYTE_W-1:0] key_register, key_register_next;
  logic [wsd_pkg::LEN_W-1:0]        payload_index, payload_index_next;

  logic                             in_fire;
  logic                             out_take;
  logic                             res_valid;
  wsd_pkg::result_t                 res;
  wsd_pkg::result_t                 out_reg;
  wsd_pkg::result_t                 skid;
  logic                             out_valid;
  logic                             skid_valid;

  logic [wsd_pkg::BYTE_W-1:0]       b;
  logic                             len_complete;
  logic                             hdr;
  logic                             empty;
  logic [3:0]                       need;
  logic [wsd_pkg::BYTE_W-1:0]       key_byte;
  logic [wsd_pkg::LEN_W-1:0]        index_inc;

  assign s_axis_tready = !skid_valid;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;
  assign b             = s_axis_tdata;

  always_comb begin
    phase_next              = phase;
    field_byte_count_next   = field_byte_count;
    first_byte_next         = first_byte;
    mask_flag_next          = mask_flag;
    length_accumulator_next = length_accumulator;
    key_register_next       = key_register;
    payload_index_next      = payload_index;
    len_complete            = 1'b0;
    hdr                     = 1'b0;
    res_valid               = 1'b0;
    empty                   = 1'b0;
    need                    = (phase == PH_EXT16) ? wsd_pkg::EXT16_BYTES
                                                  : wsd_pkg::EXT64_BYTES;
    key_byte                = mask_flag ? key_register[2'd3 - payload_index[1:0]]
                                        : '0;
    index_inc               = payload_index + 1'b1;
    res                     = '0;

    case (phase)
      PH_B1: begin
        mask_flag_next          = b[7];
        field_byte_count_next   = '0;
        length_accumulator_next = '0;
        if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
          phase_next = PH_EXT16;
        end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
          phase_next = PH_EXT64;
        end else begin
          length_accumulator_next = {{(wsd_pkg::LEN_W-7){1'b0}}, b[6:0]};
          len_complete            = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        // big-endian: shift the earlier bytes up
        length_accumulator_next = {length_accumulator[wsd_pkg::LEN_W-9:0], b};
        field_byte_count_next   = field_byte_count + 1'b1;
        len_complete            = (field_byte_count_next >= need);
      end
      PH_KEY: begin
        key_register_next     = {key_register[wsd_pkg::KEY_BYTES-2:0], b};
        field_byte_count_next = field_byte_count + 1'b1;
        hdr                   = (field_byte_count_next >= wsd_pkg::KEY_LEN_BYTES);
      end
      PH_DATA: begin
        payload_index_next = index_inc;
        res_valid          = 1'b1;
        res.kind           = wsd_pkg::KIND_PAYLOAD;
        res.data_out       = b ^ key_byte;
        res.last           = (index_inc == length_accumulator);
        if (res.last) begin
          phase_next = PH_B0;
        end
      end
      default: begin
        first_byte_next = b;
        phase_next      = PH_B1;
      end
    endcase

    if (len_complete) begin
      key_register_next = '0;
      if (mask_flag_next) begin
        phase_next            = PH_KEY;
        field_byte_count_next = '0;
      end else begin
        hdr = 1'b1;
      end
    end

    if (hdr) begin
      empty              = (length_accumulator_next == '0);
      res_valid          = 1'b1;
      res.kind           = wsd_pkg::KIND_HEADER;
      res.data_out       = '0;
      res.last           = empty;
      payload_index_next = '0;
      phase_next         = empty ? PH_B0 : PH_DATA;
    end

    res.fin            = first_byte_next[7];
    res.rsv1           = first_byte_next[6];
    res.rsv2           = first_byte_next[5];
    res.rsv3           = first_byte_next[4];
    res.opcode         = first_byte_next[3:0];
    res.masked         = mask_flag_next;
    res.payload_length = length_accumulator_next;

    if (s_axis_tuser) begin
      phase_next              = PH_B0;
      field_byte_count_next   = '0;
      first_byte_next         = '0;
      mask_flag_next          = 1'b0;
      length_accumulator_next = '0;
      key_register_next       = '0;
      payload_index_next      = '0;
      res_valid               = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_B0;
      field_byte_count   <= '0;
      first_byte         <= '0;
      mask_flag          <= 1'b0;
      length_accumulator <= '0;
      key_register       <= '0;
      payload_index      <= '0;
    end else if (in_fire) begin
      phase              <= phase_next;
      field_byte_count   <= field_byte_count_next;
      first_byte         <= first_byte_next;
      mask_flag          <= mask_flag_next;
      length_accumulator <= length_accumulator_next;
      key_register       <= key_register_next;
      payload_index      <= payload_index_next;
    end
  end

  // result register with one skid entry; input is closed while skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_valid || out_take) begin
        out_reg    <= skid;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= in_fire && res_valid;
      out_reg   <= res;
    end else if (in_fire && res_valid) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last;
  assign m_axis_tdata  = {{(wsd_pkg::OUT_TDATA_W - wsd_pkg::OUT_FIELD_W){1'b0}},
                          out_reg.data_out, out_reg.payload_length, out_reg.masked,
                          out_reg.opcode, out_reg.rsv3, out_reg.rsv2, out_reg.rsv1,
                          out_reg.fin};

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_data_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (length_accumulator != '0))
    else $error("payload phase with zero length");

  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_axis_tuser) |=> (phase == PH_B0 && payload_index == '0))
    else $error("flush did not return parser to frame start");

  a_empty_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind == wsd_pkg::KIND_HEADER && out_reg.payload_length == '0)
      |-> out_reg.last)
    else $error("empty frame header not marked last");
`endif

endmodule
